/* hdl/amg_pkg.sv */
// ----------------------------------------------------------------------------
// amg_pkg
// constants, stage types and the square root step for the milli-g magnitude
// pipeline
// ----------------------------------------------------------------------------
package amg_pkg;

  // micro m/s^2 to milli-g: q = trunc(v * 100 / 980665)
  localparam logic [6:0]  SCALE_NUM   = 7'd100;
  localparam logic [19:0] SCALE_DEN   = 20'd980665;
  // floor(2^29 * 100 / 980665), estimate is off by at most one below
  localparam logic [15:0] RECIP       = 16'd54745;
  localparam int          RECIP_SHIFT = 29;

  // smallest magnitudes that leave the signed 16-bit range
  localparam logic [31:0] SAT_POS_MIN = 32'd321344308;
  localparam logic [31:0] SAT_NEG_MIN = 32'd321354114;

  localparam logic [15:0] AXIS_MAX_MAG = 16'h7fff;
  localparam logic [15:0] AXIS_MIN_MAG = 16'h8000;

  // pipeline layout
  localparam int ST_DIVA     = 0;
  localparam int ST_DIVB     = 1;
  localparam int ST_AXES     = 2;
  localparam int ST_SQ       = 3;
  localparam int ST_SUM      = 4;
  localparam int ST_ROOT0    = 5;
  localparam int ROOT_STAGES = 4;
  localparam int ROOT_PER_ST = 4;
  localparam int NSTG        = ST_ROOT0 + ROOT_STAGES;
  localparam int LAST        = NSTG - 1;
  localparam int NAXES       = 3;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [28:0] mag;
    logic [15:0] est;
  } div_a_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [15:0] est;
    logic [20:0] rem;
  } div_b_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               sat;
  } axes_t;

  typedef struct packed {
    logic [19:0] rem;
    logic [19:0] acc;
    logic [31:0] val;
  } root_t;

  // one digit of the restoring square root, two radicand bits per step
  function automatic root_t root_step(root_t cur);
    root_t nxt;
    nxt.acc = {cur.acc[18:0], 1'b0};
    nxt.rem = {cur.rem[17:0], cur.val[31:30]};
    nxt.val = {cur.val[29:0], 2'b00};
    if (nxt.acc < nxt.rem) begin
      nxt.rem = nxt.rem - (nxt.acc | 20'd1);
      nxt.acc = nxt.acc + 20'd2;
    end
    return nxt;
  endfunction

endpackage

/* hdl/accel_magnitude_milli_g.sv */
// ----------------------------------------------------------------------------
// accel_magnitude_milli_g
// converts a three-axis acceleration sample from micro m/s^2 to saturated
// milli-g and computes the floor of its vector magnitude
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in_      request    in_valid / in_stall   accel_{x,y,z}_micro, 32b signed
//  out_     result     out_valid / out_stall {x,y,z}_milli_g 16b signed,
//                                            magnitude_milli_g 16b, axis_saturated
//
//  one request enters per cycle while in_stall is low; each result leaves the last stage
//  stages: 2 of reciprocal divide, 1 of clamp, 1 of squares, 1 of sum,
//    4 of square root at 4 digits each
//  rst_n clears only the stage valid bits, datapath registers are not reset
//  every stage has its own valid bit and holds only when the stage after it
//    is full and held, so bubbles are squeezed out under out_stall
//  in_stall rises only when all nine stages hold a request and out_stall is high
//
module accel_magnitude_milli_g
  import amg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_accel_x_micro,
  input  logic signed [31:0] in_accel_y_micro,
  input  logic signed [31:0] in_accel_z_micro,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x_milli_g,
  output logic signed [15:0] out_y_milli_g,
  output logic signed [15:0] out_z_milli_g,
  output logic        [15:0] out_magnitude_milli_g,
  output logic               out_axis_saturated
);

  // stage valid bits and advance enables
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  logic [31:0] in_ax [NAXES];

  div_a_t      diva_nxt [NAXES];
  div_a_t      diva_r   [NAXES];
  div_b_t      divb_nxt [NAXES];
  div_b_t      divb_r   [NAXES];
  logic [15:0] mag_nxt  [NAXES];
  logic [15:0] mag_r    [NAXES];
  axes_t       axes_nxt;
  axes_t       axes_r   [ST_AXES:LAST];
  logic [30:0] sq_nxt   [NAXES];
  logic [30:0] sq_r     [NAXES];
  logic [31:0] sum_nxt;
  logic [31:0] sum_r;
  root_t       root_nxt [ROOT_STAGES];
  root_t       root_r   [ROOT_STAGES];

  assign in_ax[0] = $unsigned(in_accel_x_micro);
  assign in_ax[1] = $unsigned(in_accel_y_micro);
  assign in_ax[2] = $unsigned(in_accel_z_micro);

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[LAST] = !v_r[LAST] || !out_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[ST_DIVA];

  // stage 0: magnitude, range check and reciprocal estimate of |v| / 9806.65
  always_comb begin
    logic [31:0] m;
    logic [44:0] prod;
    for (int a = 0; a < NAXES; a++) begin
      m    = in_ax[a][31] ? (~in_ax[a] + 32'd1) : in_ax[a];
      prod = {16'b0, m[28:0]} * {29'b0, RECIP};
      diva_nxt[a].neg = in_ax[a][31];
      diva_nxt[a].sat = in_ax[a][31] ? (m >= SAT_NEG_MIN) : (m >= SAT_POS_MIN);
      diva_nxt[a].mag = m[28:0];
      diva_nxt[a].est = prod[RECIP_SHIFT +: 16];
    end
  end

  // stage 1: remainder of 100*m against the estimate
  always_comb begin
    logic [35:0] num;
    logic [35:0] back;
    logic [35:0] diff;
    for (int a = 0; a < NAXES; a++) begin
      num  = {7'b0, diva_r[a].mag} * {29'b0, SCALE_NUM};
      back = {20'b0, diva_r[a].est} * {16'b0, SCALE_DEN};
      diff = num - back;
      divb_nxt[a].neg = diva_r[a].neg;
      divb_nxt[a].sat = diva_r[a].sat;
      divb_nxt[a].est = diva_r[a].est;
      divb_nxt[a].rem = diff[20:0];
    end
  end

  // stage 2: correct the quotient, saturate, restore the sign
  always_comb begin
    logic [16:0] q;
    logic [15:0] sv [NAXES];
    logic        any;
    any = 1'b0;
    for (int a = 0; a < NAXES; a++) begin
      q = {1'b0, divb_r[a].est} + {16'b0, ({1'b0, divb_r[a].rem} >= SCALE_DEN)};
      if (divb_r[a].sat) begin
        mag_nxt[a] = divb_r[a].neg ? AXIS_MIN_MAG : AXIS_MAX_MAG;
      end else begin
        mag_nxt[a] = q[15:0];
      end
      sv[a] = divb_r[a].neg ? (16'd0 - mag_nxt[a]) : mag_nxt[a];
      any   = any | divb_r[a].sat;
    end
    axes_nxt.x   = $signed(sv[0]);
    axes_nxt.y   = $signed(sv[1]);
    axes_nxt.z   = $signed(sv[2]);
    axes_nxt.sat = any;
  end

  // stage 3: squares, stage 4: sum of squares (exact, below 2^32)
  always_comb begin
    logic [31:0] p;
    for (int a = 0; a < NAXES; a++) begin
      p         = mag_r[a] * mag_r[a];
      sq_nxt[a] = p[30:0];
    end
    sum_nxt = {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
  end

  // stages 5 to 8: four root digits each
  always_comb begin
    root_t cur;
    for (int s = 0; s < ROOT_STAGES; s++) begin
      if (s == 0) begin
        cur = '{rem: 20'd0, acc: 20'd0, val: sum_r};
      end else begin
        cur = root_r[s-1];
      end
      for (int k = 0; k < ROOT_PER_ST; k++) begin
        cur = root_step(cur);
      end
      root_nxt[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[ST_DIVA]) begin
        v_r[ST_DIVA] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NAXES; a++) begin
      if (en[ST_DIVA]) begin
        diva_r[a] <= diva_nxt[a];
      end
      if (en[ST_DIVB]) begin
        divb_r[a] <= divb_nxt[a];
      end
      if (en[ST_AXES]) begin
        mag_r[a] <= mag_nxt[a];
      end
      if (en[ST_SQ]) begin
        sq_r[a] <= sq_nxt[a];
      end
    end
    if (en[ST_AXES]) begin
      axes_r[ST_AXES] <= axes_nxt;
    end
    for (int i = ST_AXES + 1; i <= LAST; i++) begin
      if (en[i]) begin
        axes_r[i] <= axes_r[i-1];
      end
    end
    if (en[ST_SUM]) begin
      sum_r <= sum_nxt;
    end
    for (int s = 0; s < ROOT_STAGES; s++) begin
      if (en[ST_ROOT0 + s]) begin
        root_r[s] <= root_nxt[s];
      end
    end
  end

  // outputs straight from the last stage
  assign out_valid          = v_r[LAST];
  assign out_x_milli_g      = axes_r[LAST].x;
  assign out_y_milli_g      = axes_r[LAST].y;
  assign out_z_milli_g      = axes_r[LAST].z;
  assign out_axis_saturated = axes_r[LAST].sat;
  assign out_magnitude_milli_g = (|root_r[ROOT_STAGES-1].acc[19:17]) ? 16'hffff
                               : root_r[ROOT_STAGES-1].acc[16:1];

  // an empty output stage never pushes back on requests
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("in_stall high with empty output stage");

  // reciprocal estimate is never more than one below the quotient
  a_div_correction: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ST_DIVB] && !divb_r[0].sat) |-> ({1'b0, divb_r[0].rem} < {SCALE_DEN, 1'b0}))
    else $error("divide remainder out of correction range");

  // magnitude covers the x axis
  a_mag_ge_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude_milli_g >= (out_x_milli_g[15] ?
      16'(-out_x_milli_g) : 16'(out_x_milli_g))))
    else $error("magnitude below x axis");

  // the root stays well inside 16 bits
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude_milli_g <= 16'd56756))
    else $error("magnitude above largest possible root");

endmodule

/* dv/tb_accel_magnitude_milli_g.sv */
// ----------------------------------------------------------------------------
// tb_accel_magnitude_milli_g
// drives acceleration samples into the milli-g magnitude pipeline, predicts
// each result in the testbench and checks every field of every result in order
// ----------------------------------------------------------------------------
module tb_accel_magnitude_milli_g
  import amg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // micro m/s^2 per milli-g is 980665 / 100
  localparam longint MG_SCALE_NUM = 100;
  localparam longint MG_SCALE_DEN = 980665;
  localparam int     AXIS_HI      = 32767;
  localparam int     AXIS_LO      = -32768;
  localparam int     MAX_WAIT     = 11;
  // pipeline is 9 deep, give it some margin after the last result
  localparam int     SETTLE_CYCLES = 20;
  localparam int     DRAIN_LIMIT   = 5000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic        [15:0] mag;
    logic               sat;
  } milli_g_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_accel_x_micro;
  logic signed [31:0] in_accel_y_micro;
  logic signed [31:0] in_accel_z_micro;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_x_milli_g;
  logic signed [15:0] out_y_milli_g;
  logic signed [15:0] out_z_milli_g;
  logic        [15:0] out_magnitude_milli_g;
  logic               out_axis_saturated;

  // results predicted at request acceptance, oldest first
  milli_g_result_t expected_results[$];
  milli_g_result_t oldest_result;
  int              mismatches   = 0;
  int              results_seen = 0;
  // idling switches for the request side and the result side
  bit              tx_idle_en   = 1'b1;
  bit              rx_idle_en   = 1'b1;
  // cycles the result side still holds out_stall high
  int              rx_wait      = 0;

  accel_magnitude_milli_g u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_accel_x_micro      (in_accel_x_micro),
    .in_accel_y_micro      (in_accel_y_micro),
    .in_accel_z_micro      (in_accel_z_micro),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_x_milli_g         (out_x_milli_g),
    .out_y_milli_g         (out_y_milli_g),
    .out_z_milli_g         (out_z_milli_g),
    .out_magnitude_milli_g (out_magnitude_milli_g),
    .out_axis_saturated    (out_axis_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // scale one axis to milli-g, truncating toward zero, then clamp to 16 bits
  function automatic logic signed [15:0] scale_axis_milli_g(
    input logic signed [31:0] micro,
    inout logic               clamped
  );
    longint scaled;
    scaled = (longint'(micro) * MG_SCALE_NUM) / MG_SCALE_DEN;
    if (scaled > AXIS_HI) begin
      clamped = 1'b1;
      return 16'sh7fff;
    end
    if (scaled < AXIS_LO) begin
      clamped = 1'b1;
      return 16'sh8000;
    end
    return 16'(scaled);
  endfunction

  // floor square root by setting root bits from the top while the square fits
  function automatic logic [15:0] floor_sqrt_u32(input logic [31:0] radicand);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (longint'(trial) * longint'(trial) <= longint'(radicand))
        root = trial;
    end
    // never reached, the largest sum has a root near 56756
    if (root > 32'd65535)
      root = 32'd65535;
    return root[15:0];
  endfunction

  function automatic milli_g_result_t predict_milli_g(
    input logic signed [31:0] ax,
    input logic signed [31:0] ay,
    input logic signed [31:0] az
  );
    milli_g_result_t r;
    logic            clamped;
    int              xi, yi, zi;
    logic [31:0]     sum_sq;
    clamped = 1'b0;
    r.x = scale_axis_milli_g(ax, clamped);
    r.y = scale_axis_milli_g(ay, clamped);
    r.z = scale_axis_milli_g(az, clamped);
    xi = r.x;
    yi = r.y;
    zi = r.z;
    // each square is at most 2^30, the sum fits in 32 unsigned bits
    sum_sq = 32'(xi * xi) + 32'(yi * yi) + 32'(zi * zi);
    r.mag = floor_sqrt_u32(sum_sq);
    r.sat = clamped;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // entered and left at a falling edge; optional gap, then hold until accepted
  task automatic send_sample(
    input logic signed [31:0] ax,
    input logic signed [31:0] ay,
    input logic signed [31:0] az
  );
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_accel_x_micro <= ax;
    in_accel_y_micro <= ay;
    in_accel_z_micro <= az;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_milli_g(ax, ay, az));
    @(negedge clk);
  endtask

  // drop the request and hold off until every predicted result has come back
  task automatic wait_results_drained();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      cycles++;
    end while (expected_results.size() != 0 && cycles < DRAIN_LIMIT);
    if (expected_results.size() != 0) begin
      $display("%0t: results outstanding: expected 0, actual %0d",
               $time, expected_results.size());
      mismatches++;
    end
  endtask

  // random axis value, weighted toward the ranges that matter
  function automatic logic signed [31:0] random_micro();
    int kind;
    int base;
    kind = $urandom_range(0, 9);
    case (kind)
      // whole 32-bit range, mostly saturating
      0, 1, 2: return $urandom;
      // anywhere inside the unsaturated range
      3, 4, 5, 6: return int'($urandom_range(0, 642698226)) - 321354113;
      // around a few milli-g
      7: return int'($urandom_range(0, 40000)) - 20000;
      // right at one of the saturation edges
      8: begin
        base = $urandom_range(0, 1) ? int'(SAT_POS_MIN) : -int'(SAT_NEG_MIN);
        return base + int'($urandom_range(0, 4)) - 2;
      end
      // right at a milli-g step, where truncation flips
      default: begin
        base = int'((longint'($urandom_range(0, 32767)) * MG_SCALE_DEN) / MG_SCALE_NUM);
        base = $urandom_range(0, 1) ? base : -base;
        return base + int'($urandom_range(0, 2)) - 1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // out_stall changes only at the falling edge
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(
    input string              field,
    input logic signed [31:0] want,
    input logic signed [31:0] got
  );
    if (got !== want) begin
      $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
               $time, results_seen, field, want, got);
      mismatches++;
    end
  endtask

  // every accepted result is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual x=%0d y=%0d z=%0d mag=%0d sat=%0b",
                 $time, out_x_milli_g, out_y_milli_g, out_z_milli_g,
                 out_magnitude_milli_g, out_axis_saturated);
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("x_milli_g", oldest_result.x, out_x_milli_g);
        check_field("y_milli_g", oldest_result.y, out_y_milli_g);
        check_field("z_milli_g", oldest_result.z, out_z_milli_g);
        check_field("magnitude_milli_g", oldest_result.mag, out_magnitude_milli_g);
        check_field("axis_saturated", oldest_result.sat, out_axis_saturated);
      end
      results_seen++;
      rx_wait = rx_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, truncation steps and saturation edges
  task automatic test_directed_corners();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_sample(0, 0, 0);
    send_sample(1, -1, 0);
    // one micro below and at the first milli-g step, both signs
    send_sample(9806, 9807, -9807);
    send_sample(-9806, -1, 1);
    // exactly 300 and 400 milli-g gives a round magnitude of 500
    send_sample(2941995, 3922660, 0);
    send_sample(9806650, 9806649, -9806650);
    // last values inside the 16-bit range
    send_sample(int'(SAT_POS_MIN) - 1, -(int'(SAT_NEG_MIN) - 1), 0);
    // first values outside it
    send_sample(int'(SAT_POS_MIN), 0, 0);
    send_sample(0, -int'(SAT_NEG_MIN), 0);
    send_sample(0, 0, int'(SAT_POS_MIN));
    // full-scale inputs, all axes clamped, largest possible magnitude
    send_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_sample(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_sample(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    // large unclamped magnitude, two axes at 32767 and one at -32768 milli-g
    send_sample(int'(SAT_POS_MIN) - 1, int'(SAT_POS_MIN) - 1, -(int'(SAT_NEG_MIN) - 1));
    send_sample(-1, -1, -1);
    send_sample(32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff);
    wait_results_drained();
  endtask

  // one request per cycle and no result stall, the pipeline runs full rate
  task automatic test_random_streaming(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_sample(random_micro(), random_micro(), random_micro());
  endtask

  // random gaps and stalls on both sides
  task automatic test_random_with_idling(input int count);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (count) send_sample(random_micro(), random_micro(), random_micro());
  endtask

  // requests back to back while results stall, so the pipeline fills and
  // in_stall has to push back
  task automatic test_output_backpressure(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    repeat (count) send_sample(random_micro(), random_micro(), random_micro());
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_accel_x_micro = '0;
    in_accel_y_micro = '0;
    in_accel_z_micro = '0;
    out_stall        = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_corners();
    test_random_streaming(300);
    test_random_with_idling(400);
    // pause until the pipeline is empty, then restart from idle
    wait_results_drained();
    test_output_backpressure(300);
    test_random_streaming(100);
    test_random_with_idling(200);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
